### rtl/core/tws_pkg.sv
// shared types and constants of the timer wheel scheduler
`default_nettype none

package tws_pkg;

   localparam int TICK_W     = 48;
   localparam int ID_W       = 32;
   localparam int DUR_W      = 32;
   localparam int MIN_DUR_W  = 16;
   localparam int SHIFT_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // at most this many expiry beats per tick
   localparam int MAX_RESULTS = 64;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [MIN_DUR_W-1:0] MIN_DURATION_RESET = 16'd16;
   localparam logic [SHIFT_W-1:0]   TICK_SHIFT_RESET   = 4'd4;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] KIND_ADDED   = 2'd0;
   localparam logic [1:0] KIND_SHORT   = 2'd1;
   localparam logic [1:0] KIND_FULL    = 2'd2;
   localparam logic [1:0] KIND_EXPIRED = 2'd3;

   // register index, taken from csr_paddr[2]
   localparam logic REG_MIN_DURATION = 1'b0;
   localparam logic REG_TICK_SHIFT   = 1'b1;

   typedef struct packed {
      logic             command;
      logic [DUR_W-1:0] duration_ms;
      logic [ID_W-1:0]  requested_id;
   } req_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] timer_id;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [MIN_DUR_W-1:0] min_duration_ms;
      logic [SHIFT_W-1:0]   tick_shift;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [TICK_W-1:0] target;
      logic [ID_W-1:0]   id;
   } entry_type;

endpackage

`default_nettype wire

### rtl/core/tws_csr.sv
// configuration registers of the timer wheel scheduler
`default_nettype none

module tws_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tws_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tws_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [tws_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready,
   output tws_pkg::cfg_type                        cfg
);
   import tws_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MIN_DURATION: cfg_in.min_duration_ms = csr_pwdata[MIN_DUR_W-1:0];
            REG_TICK_SHIFT:   cfg_in.tick_shift      = csr_pwdata[SHIFT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_DURATION: csr_prdata = {{(CSR_DATA_W-MIN_DUR_W){1'b0}}, cfg_ff.min_duration_ms};
         REG_TICK_SHIFT:   csr_prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, cfg_ff.tick_shift};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_duration_ms <= MIN_DURATION_RESET;
         cfg_ff.tick_shift      <= TICK_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/timer_wheel_scheduler_unit.sv
// timer wheel scheduler top level: command channel, result strobe, entry store
`default_nettype none

// Timer scheduler kept in one entry memory of TIMER_ENTRIES words
// (valid, absolute target tick, event id), read through a registered output.
// A command beat is taken at a clock edge with start high and busy low.
// An add beat that is too short answers in the cycle after it is taken.
// Any other add scans the memory from entry 0 until the first free entry,
// which it fills and answers for; a full store answers once the scan has
// checked the last entry. A tick beat always scans the whole memory, one
// entry a cycle; its expiry beats come out along the scan, one at most per
// cycle, the last one flagged, and busy stays high until the final beat
// is out. The one read port of the memory sets this pace.
// Result beats show on rsp_valid for one cycle; the receiver cannot
// stall them. A new command may be taken while the previous result shows.
// After reset the block sweeps the memory to clear every entry, which
// keeps busy high until the sweep is done; csr writes are taken at once.
module timer_wheel_scheduler_unit #(
   parameter int TIMER_ENTRIES = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire tws_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   output tws_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tws_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tws_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [tws_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import tws_pkg::*;

   localparam int AW = $clog2(TIMER_ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TIMER_ENTRIES - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   cfg_type cfg;

   tws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   entry_type entry_mem [TIMER_ENTRIES];
   entry_type rd_data_ff;

   logic [1:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 issue_on_ff, issue_on_in;
   logic [AW-1:0]        issue_addr_ff, issue_addr_in;
   logic                 chk_on_ff, chk_on_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 chk_end_ff, chk_end_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [ID_W-1:0]      auto_id_ff, auto_id_in;
   logic                 pend_on_ff, pend_on_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   entry_type            mem_wdata;
   logic [TICK_W-1:0]    target_sum;
   logic [ID_W-1:0]      add_id;
   logic                 hit;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign target_sum = tick_ff + {{(TICK_W-DUR_W){1'b0}}, req_ff.duration_ms >> cfg.tick_shift};
   assign add_id     = (req_ff.requested_id != '0) ? req_ff.requested_id : auto_id_ff;
   assign hit        = chk_on_ff && rd_data_ff.valid && (rd_data_ff.target == tick_ff);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      clr_addr_in   = clr_addr_ff;
      issue_on_in   = issue_on_ff;
      issue_addr_in = issue_addr_ff;
      chk_on_in     = 1'b0;
      chk_idx_in    = issue_addr_ff;
      chk_end_in    = (issue_addr_ff == LAST_ADDR);
      tick_in       = tick_ff;
      auto_id_in    = auto_id_ff;
      pend_on_in    = pend_on_ff;
      pend_id_in    = pend_id_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = chk_idx_ff;
      mem_wdata     = rd_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command == CMD_ADD &&
                   req_data.duration_ms < {{(DUR_W-MIN_DUR_W){1'b0}}, cfg.min_duration_ms}) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.kind     = KIND_SHORT;
                  rsp_data_in.timer_id = '0;
                  rsp_data_in.last     = 1'b1;
               end else begin
                  state_in      = ST_SCAN;
                  issue_on_in   = 1'b1;
                  issue_addr_in = '0;
                  pend_on_in    = 1'b0;
                  cnt_in        = '0;
               end
            end
         end
         ST_SCAN: begin
            chk_on_in = issue_on_ff;
            if (issue_on_ff) begin
               issue_addr_in = issue_addr_ff + 1'b1;
               if (issue_addr_ff == LAST_ADDR) begin
                  issue_on_in = 1'b0;
               end
            end
            if (chk_on_ff) begin
               if (req_ff.command == CMD_ADD) begin
                  if (!rd_data_ff.valid) begin
                     mem_we               = 1'b1;
                     mem_wdata.valid      = 1'b1;
                     mem_wdata.target     = target_sum;
                     mem_wdata.id         = add_id;
                     if (req_ff.requested_id == '0) begin
                        auto_id_in = auto_id_ff + 1'b1;
                     end
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.kind     = KIND_ADDED;
                     rsp_data_in.timer_id = add_id;
                     rsp_data_in.last     = 1'b1;
                     issue_on_in          = 1'b0;
                     chk_on_in            = 1'b0;
                     state_in             = ST_IDLE;
                  end else if (chk_end_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.kind     = KIND_FULL;
                     rsp_data_in.timer_id = '0;
                     rsp_data_in.last     = 1'b1;
                     state_in             = ST_IDLE;
                  end
               end else begin
                  if (hit) begin
                     mem_we          = 1'b1;
                     mem_wdata.valid = 1'b0;
                     // one expiry held back so the final one can carry last
                     if (cnt_ff < RES_CNT_W'(MAX_RESULTS)) begin
                        if (pend_on_ff) begin
                           rsp_valid_in         = 1'b1;
                           rsp_data_in.kind     = KIND_EXPIRED;
                           rsp_data_in.timer_id = pend_id_ff;
                           rsp_data_in.last     = 1'b0;
                        end
                        pend_on_in = 1'b1;
                        pend_id_in = rd_data_ff.id;
                        cnt_in     = cnt_ff + 1'b1;
                     end
                  end
                  if (chk_end_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (pend_on_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = KIND_EXPIRED;
               rsp_data_in.timer_id = pend_id_ff;
               rsp_data_in.last     = 1'b1;
            end
            pend_on_in = 1'b0;
            tick_in    = tick_ff + 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[issue_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_on_ff  <= 1'b0;
         chk_on_ff    <= 1'b0;
         tick_ff      <= '0;
         auto_id_ff   <= '0;
         pend_on_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_on_ff  <= issue_on_in;
         chk_on_ff    <= chk_on_in;
         tick_ff      <= tick_in;
         auto_id_ff   <= auto_id_in;
         pend_on_ff   <= pend_on_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      issue_addr_ff <= issue_addr_in;
      chk_idx_ff    <= chk_idx_in;
      chk_end_ff    <= chk_end_in;
      pend_id_ff    <= pend_id_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("expiry count above limit");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result beat during clearing sweep");

   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind != KIND_EXPIRED |-> rsp_data_ff.last)
      else $error("add answer without last");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick counter did not advance");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// testbench for the timer wheel scheduler: command driver, result monitor, scheduler model
module tb_top;
   import tws_pkg::*;

   localparam int ENTRIES       = 64;
   localparam int CLOCK_PERIOD  = 12;
   localparam int SETTLE_CYCLES = ENTRIES + 16;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MIN_DURATION = {REG_MIN_DURATION, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_TICK_SHIFT   = {REG_TICK_SHIFT, 2'b00};

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic                    steady;
      req_type                 item;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [CSR_DATA_W-1:0]   data;
   } op_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   timer_wheel_scheduler_unit #(
      .TIMER_ENTRIES(ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // scheduler model state
   logic                 live [ENTRIES];
   logic [TICK_W-1:0]    goal [ENTRIES];
   logic [ID_W-1:0]      owner_id [ENTRIES];
   logic [TICK_W-1:0]    tick_now;
   logic [ID_W-1:0]      auto_id;
   logic [MIN_DUR_W-1:0] cfg_min;
   logic [SHIFT_W-1:0]   cfg_shift;

   rsp_type outcomes [$];
   op_type  pending [$];

   // stimulus-side view of the configuration
   int unsigned gen_min;
   int unsigned gen_shift;

   logic beat_taken = 1'b0;
   logic draining = 1'b0;
   int   settle = 0;
   logic [1:0] csr_step = 2'd0;

   int mismatches = 0;
   int commands_taken = 0;
   int csr_writes = 0;
   int kind_seen [4];

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s: got kind %0d id %h last %0d, %s %0d id %h last %0d",
                  $time, what, got.kind, got.timer_id, got.last,
                  "want kind", want.kind, want.timer_id, want.last);
   endtask

   task automatic run_scheduler(input req_type r);
      rsp_type beat;
      int i;
      int slot;
      int hits;
      int last_at;
      logic [DUR_W-1:0] offset;
      beat = '0;
      beat.last = 1'b1;
      if (r.command == CMD_ADD) begin
         slot = -1;
         for (i = ENTRIES - 1; i >= 0; i--)
            if (!live[i]) slot = i;
         if (r.duration_ms < cfg_min) begin
            beat.kind = KIND_SHORT;
         end else if (slot < 0) begin
            beat.kind = KIND_FULL;
         end else begin
            beat.kind = KIND_ADDED;
            if (r.requested_id != '0) begin
               beat.timer_id = r.requested_id;
            end else begin
               beat.timer_id = auto_id;
               auto_id = auto_id + 1'b1;
            end
            offset = r.duration_ms >> cfg_shift;
            live[slot] = 1'b1;
            goal[slot] = tick_now + TICK_W'(offset);
            owner_id[slot] = beat.timer_id;
         end
         outcomes.push_back(beat);
      end else begin
         hits = 0;
         last_at = -1;
         for (i = 0; i < ENTRIES; i++) begin
            if (live[i] && goal[i] == tick_now) begin
               if (hits < MAX_RESULTS) begin
                  beat.kind = KIND_EXPIRED;
                  beat.timer_id = owner_id[i];
                  beat.last = 1'b0;
                  outcomes.push_back(beat);
                  last_at = outcomes.size() - 1;
                  hits++;
               end
               live[i] = 1'b0;
            end
         end
         if (last_at >= 0) begin
            beat = outcomes[last_at];
            beat.last = 1'b1;
            outcomes[last_at] = beat;
         end
         tick_now = tick_now + 1'b1;
      end
   endtask

   // monitor: results, accepted commands and register writes, all at the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (rsp_valid === 1'b1) begin
            if (outcomes.size() == 0) begin
               report_mismatch("beat with nothing pending", rsp_data, '0);
            end else begin
               want = outcomes.pop_front();
               kind_seen[want.kind]++;
               if (rsp_data.kind !== want.kind)
                  report_mismatch("kind", rsp_data, want);
               if (rsp_data.timer_id !== want.timer_id)
                  report_mismatch("timer_id", rsp_data, want);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data, want);
            end
         end
         if (start && !busy) begin
            run_scheduler(req_data);
            commands_taken++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_MIN_DURATION)
               cfg_min = csr_pwdata[MIN_DUR_W-1:0];
            else
               cfg_min = cfg_min;
            if (csr_paddr[2] == REG_TICK_SHIFT)
               cfg_shift = csr_pwdata[SHIFT_W-1:0];
            csr_writes++;
         end
      end
   end

   // driver: one op from the pending queue at a time, inputs change at the falling edge
   always @(negedge clock) begin : driver
      logic   nxt_start;
      op_type op;
      nxt_start = 1'b0;
      if (reset) begin
         nxt_start = 1'b0;
      end else if (start && !beat_taken) begin
         nxt_start = 1'b1;
      end else if (csr_step == 2'd1) begin
         csr_penable <= 1'b1;
         csr_step <= 2'd2;
      end else if (csr_step == 2'd2) begin
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         csr_step <= 2'd0;
      end else if (draining) begin
         // a tick without expiries may still be scanning, so wait out its latency
         if (outcomes.size() != 0)
            settle <= 0;
         else if (settle >= SETTLE_CYCLES)
            draining <= 1'b0;
         else
            settle <= settle + 1;
      end else if (pending.size() != 0) begin
         op = pending[0];
         case (op.kind)
            OP_ITEM: begin
               if (op.steady || $urandom_range(0, 99) >= 7) begin
                  req_data <= op.item;
                  nxt_start = 1'b1;
                  void'(pending.pop_front());
               end
            end
            OP_CSR: begin
               csr_psel <= 1'b1;
               csr_pwrite <= 1'b1;
               csr_paddr <= op.addr;
               csr_pwdata <= op.data;
               csr_step <= 2'd1;
               void'(pending.pop_front());
            end
            default: begin
               draining <= 1'b1;
               settle <= 0;
               void'(pending.pop_front());
            end
         endcase
      end
      start <= nxt_start;
   end

   task automatic queue_op(input op_kind_type kind, input logic steady, input req_type item,
                           input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      op_type op;
      op.kind = kind;
      op.steady = steady;
      op.item = item;
      op.addr = addr;
      op.data = data;
      pending.push_back(op);
   endtask

   task automatic send_add(input logic [DUR_W-1:0] dur, input logic [ID_W-1:0] id,
                           input logic steady);
      req_type r;
      r.command = CMD_ADD;
      r.duration_ms = dur;
      r.requested_id = id;
      queue_op(OP_ITEM, steady, r, '0, '0);
   endtask

   // the duration and id of a tick beat carry noise the block must ignore
   task automatic send_tick(input logic steady);
      req_type r;
      r.command = CMD_TICK;
      r.duration_ms = $urandom;
      r.requested_id = $urandom;
      queue_op(OP_ITEM, steady, r, '0, '0);
   endtask

   task automatic set_config(input int unsigned min_ms, input int unsigned shift);
      queue_op(OP_DRAIN, 1'b0, '0, '0, '0);
      queue_op(OP_CSR, 1'b0, '0, ADDR_MIN_DURATION, CSR_DATA_W'(min_ms));
      queue_op(OP_CSR, 1'b0, '0, ADDR_TICK_SHIFT, CSR_DATA_W'(shift));
      gen_min = min_ms;
      gen_shift = shift;
   endtask

   task automatic random_phase(input int count, input logic steady);
      int n;
      int unsigned r;
      logic [DUR_W-1:0] dur;
      logic [ID_W-1:0] id;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         id = ($urandom_range(0, 99) < 35) ? '0 : ID_W'($urandom);
         if (r < 42) begin
            send_tick(steady);
         end else if (r < 84) begin
            // lands up to five ticks ahead so that later ticks expire it
            dur = (DUR_W'($urandom_range(0, 5)) << gen_shift)
                  | DUR_W'($urandom_range(0, (1 << gen_shift) - 1));
            send_add(dur, id, steady);
         end else if (r < 95) begin
            send_add(DUR_W'($urandom_range(0, gen_min - 1)), id, steady);
         end else begin
            send_add(DUR_W'($urandom), ID_W'($urandom), steady);
         end
      end
   endtask

   initial begin : stimulus
      int n;
      int guard;
      int unsigned shift;
      for (n = 0; n < ENTRIES; n++) begin
         live[n] = 1'b0;
         goal[n] = '0;
         owner_id[n] = '0;
      end
      tick_now = '0;
      auto_id = '0;
      cfg_min = MIN_DURATION_RESET;
      cfg_shift = TICK_SHIFT_RESET;
      gen_min = MIN_DURATION_RESET;
      gen_shift = TICK_SHIFT_RESET;
      for (n = 0; n < 4; n++) kind_seen[n] = 0;

      // directed: short adds, automatic ids, shared target, zero offset, widest minimum
      send_add(32'd0, 32'd7, 1'b0);
      send_add(32'd15, 32'd0, 1'b0);
      send_add(32'd16, 32'd0, 1'b0);
      send_add(32'd47, 32'hFFFF_FFFF, 1'b0);
      send_add(32'd32, 32'd0, 1'b0);
      for (n = 0; n < 4; n++) send_tick(1'b0);
      set_config(1, 15);
      send_add(32'd1, 32'd3, 1'b0);
      send_add(32'd32767, 32'h8000_0001, 1'b0);
      send_add(32'd32768, 32'd0, 1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      set_config(65535, 15);
      send_add(32'd65534, 32'd9, 1'b0);
      send_add(32'd65535, 32'd0, 1'b0);
      send_tick(1'b0);
      send_tick(1'b0);

      // fill the store with one shared target, overflow it, then expire it all in one tick
      set_config(MIN_DURATION_RESET, TICK_SHIFT_RESET);
      for (n = 0; n < ENTRIES + 4; n++)
         send_add(32'd48 | DUR_W'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? '0 : ID_W'($urandom), 1'b0);
      for (n = 0; n < 4; n++) send_tick(1'b0);

      set_config(1, 0);
      send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      random_phase(35, 1'b0);
      set_config(65535, 15);
      random_phase(35, 1'b0);
      shift = $urandom_range(1, 14);
      set_config($urandom_range(1, 1 << shift), shift);
      random_phase(35, 1'b0);
      set_config(MIN_DURATION_RESET, TICK_SHIFT_RESET);
      random_phase(35, 1'b1);
      set_config(1, 15);
      random_phase(35, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending.size() != 0 || draining || start || csr_step != 2'd0)
         @(posedge clock);
      guard = 0;
      while (outcomes.size() != 0 && guard < 10 * SETTLE_CYCLES) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcomes.size() != 0)
         report_mismatch($sformatf("%0d beats never came", outcomes.size()), '0, outcomes[0]);

      $display("covered %0d commands and %0d register writes", commands_taken, csr_writes);
      $display("beats: %0d added, %0d too short, %0d store full, %0d expired",
               kind_seen[KIND_ADDED], kind_seen[KIND_SHORT], kind_seen[KIND_FULL],
               kind_seen[KIND_EXPIRED]);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #(CLOCK_PERIOD * 500000);
      $display("simulation failed");
      $finish;
   end

endmodule
